// ===== hw/rtl/particle_table_update_defines.svh =====
// Assertion macros shared by the particle table RTL.
`ifndef PARTICLE_TABLE_UPDATE_DEFINES_SVH
`define PARTICLE_TABLE_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptu_pkg.sv =====
// Types, constants and helpers for the particle table update block.
`default_nettype none
package ptu_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int TABLE_DEPTH       = 64;
    localparam int ADDR_W            = 6;
    localparam int IN_DATA_W         = 288;
    localparam int OUT_DATA_W        = 112;
    localparam int DIV_STEPS         = 16;
    localparam int LERP_STEPS        = 6;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One stored particle.
    typedef struct packed {
        logic [47:0] position;
        logic [47:0] velocity;
        logic [47:0] acceleration;
        logic [31:0] scale_span;
        logic [63:0] color_span;
        logic [31:0] rotation_span;
        logic [15:0] age;
        logic [15:0] life;
    } ptu_entry_t;

    // Three independent wrapping 16-bit lane additions.
    function automatic logic [47:0] lane_add(input logic [47:0] a, input logic [47:0] b);
        logic [47:0] r;
        for (int i = 0; i < 3; i++) begin
            r[16*i +: 16] = a[16*i +: 16] + b[16*i +: 16];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ptu_table.sv =====
// Particle table memory: one write port and one registered read port.
`default_nettype none
module ptu_table (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [ptu_pkg::ADDR_W-1:0]   wr_addr,
    input  wire ptu_pkg::ptu_entry_t          wr_data,
    input  wire logic                         rd_en,
    input  wire logic [ptu_pkg::ADDR_W-1:0]   rd_addr,
    output ptu_pkg::ptu_entry_t               rd_data
);

    ptu_pkg::ptu_entry_t mem [ptu_pkg::TABLE_DEPTH];
    ptu_pkg::ptu_entry_t rd_data_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/particle_table_update.sv =====
// Particle table update: an add stores a new particle (dropped when the table is full)
// and produces no beat. A tick drops expired particles and, for each survivor, runs the
// 16-step rate divider (skipped for one that reaches the end of its life) and the shared multiplier.
// Each vertex is held until the next survivor is written or the scan ends, when the last
// survivor's beat is offered with m_tlast set; output stalls hold up the scan.
// Synchronous active-low reset empties the table; stored entries are not cleared.
`default_nettype none
module particle_table_update #(
    parameter int MAX_PARTICLES = ptu_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // start_position, start_velocity, acceleration, birth_scale, final_scale,
    // birth_colour, final_colour, rotation_start, rotation_end, life_frames
    input  wire logic [ptu_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // vertex_position, vertex_scale, vertex_color, vertex_rotation
    output logic [ptu_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);

    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int AW    = ptu_pkg::ADDR_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [15:0]       age_reg, age_next;
    logic [15:0]       rem_reg, rem_next;
    logic [15:0]       rate_reg, rate_next;
    logic [4:0]        step_reg, step_next;
    logic signed [34:0] prod_reg, prod_next;
    logic signed [16:0] base_reg, base_next;
    logic [31:0]       vcol_reg, vcol_next;
    logic [15:0]       vscale_reg, vscale_next;
    logic [15:0]       vrot_reg, vrot_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [111:0]      hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;
    logic [111:0]      out_reg, out_next;
    logic              out_last_reg, out_last_next;

    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    ptu_pkg::ptu_entry_t  wr_data, rd_entry, new_entry;

    logic               in_accept;
    logic               out_free;
    logic [16:0]        div_trial;
    logic signed [16:0] op_s, op_e;
    logic signed [17:0] op_diff;
    logic [2:0]         res_sel;
    logic signed [18:0] lerp_sum;
    logic [47:0]        vel_new, pos_new;

    ptu_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // New particle built from the input beat.
    always_comb begin
        new_entry.position      = s_tdata[47:0];
        new_entry.velocity      = s_tdata[95:48];
        new_entry.acceleration  = s_tdata[143:96];
        new_entry.scale_span    = s_tdata[175:144];
        new_entry.color_span    = s_tdata[239:176];
        new_entry.rotation_span = s_tdata[271:240];
        new_entry.age           = 16'd0;
        new_entry.life          = s_tdata[287:272];
    end

    // Euler step of the entry under update.
    assign vel_new = ptu_pkg::lane_add(rd_entry.velocity, rd_entry.acceleration);
    assign pos_new = ptu_pkg::lane_add(rd_entry.position, vel_new);

    // Restoring divider trial shift.
    assign div_trial = {rem_reg, 1'b0};

    // Interpolation operand selection for the shared multiplier.
    always_comb begin
        op_s = '0;
        op_e = '0;
        case (step_reg[2:0])
            3'd0: begin
                op_s = {9'd0, rd_entry.color_span[7:0]};
                op_e = {9'd0, rd_entry.color_span[39:32]};
            end
            3'd1: begin
                op_s = {9'd0, rd_entry.color_span[15:8]};
                op_e = {9'd0, rd_entry.color_span[47:40]};
            end
            3'd2: begin
                op_s = {9'd0, rd_entry.color_span[23:16]};
                op_e = {9'd0, rd_entry.color_span[55:48]};
            end
            3'd3: begin
                op_s = {9'd0, rd_entry.color_span[31:24]};
                op_e = {9'd0, rd_entry.color_span[63:56]};
            end
            3'd4: begin
                op_s = {1'b0, rd_entry.scale_span[15:0]};
                op_e = {1'b0, rd_entry.scale_span[31:16]};
            end
            3'd5: begin
                op_s = {rd_entry.rotation_span[15], rd_entry.rotation_span[15:0]};
                op_e = {rd_entry.rotation_span[31], rd_entry.rotation_span[31:16]};
            end
            default: begin
                op_s = '0;
                op_e = '0;
            end
        endcase
    end

    assign op_diff  = 18'(op_e) - 18'(op_s);
    assign res_sel  = step_reg[2:0] - 3'd1;
    // Arithmetic shift of the product floors toward minus infinity.
    assign lerp_sum = 19'(base_reg) + prod_reg[34:16];

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        kept_next       = kept_reg;
        age_next        = age_reg;
        rem_next        = rem_reg;
        rate_next       = rate_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        base_next       = base_reg;
        vcol_next       = vcol_reg;
        vscale_next     = vscale_reg;
        vrot_next       = vrot_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg - AW'(1);
        wr_data         = new_entry;
        rd_en           = 1'b0;
        rd_addr         = head_reg + AW'(scan_reg);

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser == ptu_pkg::OP_ADD) begin
                        if (count_reg < CNT_W'(MAX_PARTICLES)) begin
                            wr_en      = 1'b1;
                            head_next  = head_reg - AW'(1);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else begin
                        scan_next  = '0;
                        kept_next  = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (scan_reg == count_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (rd_entry.age < rd_entry.life) begin
                    age_next  = rd_entry.age + 16'd1;
                    rem_next  = rd_entry.age + 16'd1;
                    step_next = '0;
                    if (rd_entry.age + 16'd1 == rd_entry.life) begin
                        rate_next  = 16'hFFFF;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_DIV;
                    end
                end else begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle.
                if (div_trial >= {1'b0, rd_entry.life}) begin
                    rem_next  = 16'(div_trial - {1'b0, rd_entry.life});
                    rate_next = {rate_reg[14:0], 1'b1};
                end else begin
                    rem_next  = div_trial[15:0];
                    rate_next = {rate_reg[14:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(ptu_pkg::DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // Multiply one operand, add the previous product.
                if (step_reg < 5'(ptu_pkg::LERP_STEPS)) begin
                    prod_next = op_diff * $signed({1'b0, rate_reg});
                    base_next = op_s;
                end
                if (step_reg != 5'd0) begin
                    case (res_sel)
                        3'd0: vcol_next[7:0]   = lerp_sum[7:0];
                        3'd1: vcol_next[15:8]  = lerp_sum[7:0];
                        3'd2: vcol_next[23:16] = lerp_sum[7:0];
                        3'd3: vcol_next[31:24] = lerp_sum[7:0];
                        3'd4: vscale_next      = lerp_sum[15:0];
                        3'd5: vrot_next        = lerp_sum[15:0];
                        default: vrot_next     = vrot_reg;
                    endcase
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(ptu_pkg::LERP_STEPS)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // The held vertex is passed on once a later survivor shows it is not last.
                if (!(hold_valid_reg && !out_free)) begin
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next          = 1'b1;
                    hold_next                = {vrot_reg, vcol_reg, vscale_reg, pos_new};
                    wr_en                    = 1'b1;
                    wr_addr                  = head_reg + AW'(kept_reg);
                    wr_data                  = rd_entry;
                    wr_data.position         = pos_new;
                    wr_data.velocity         = vel_new;
                    wr_data.age              = age_reg;
                    kept_next                = kept_reg + CNT_W'(1);
                    scan_next                = scan_reg + CNT_W'(1);
                    state_next               = ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg) begin
                    count_next = kept_reg;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    count_next      = kept_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        kept_reg     <= kept_next;
        age_reg      <= age_next;
        rem_reg      <= rem_next;
        rate_reg     <= rate_next;
        step_reg     <= step_next;
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        vcol_reg     <= vcol_next;
        vscale_reg   <= vscale_next;
        vrot_reg     <= vrot_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    `include "particle_table_update_defines.svh"

    `PTU_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_PARTICLES), "live count above capacity")
    `PTU_ASSERT_IMPL(a_kept_bound, aclk, aresetn, state_reg != ST_IDLE, kept_reg <= scan_reg, "survivors exceed scanned entries")
    `PTU_ASSERT_NEXT(a_add_grows, aclk, aresetn, in_accept && s_tuser == ptu_pkg::OP_ADD && count_reg < CNT_W'(MAX_PARTICLES), count_reg == $past(count_reg) + CNT_W'(1), "add did not grow the table")

endmodule
`default_nettype wire
